[rtl/jss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jss_pkg
// Shared widths, codes and types of the Jacobi stencil sweep unit.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int CELL_BITS  = 32;
  localparam int ACC_BITS   = CELL_BITS + 2;
  localparam int ROW_BITS   = 6;
  localparam int COL_BITS   = 6;
  localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int DIM_BITS   = 7;
  localparam int SWEEP_BITS = 8;
  localparam int CFG_BITS   = 8;

  localparam logic [DIM_BITS-1:0]   MAX_ROWS       = 7'd64;
  localparam logic [DIM_BITS-1:0]   MAX_COLS       = 7'd64;
  localparam logic [DIM_BITS-1:0]   ROWS_RESET     = 7'd64;
  localparam logic [DIM_BITS-1:0]   COLS_RESET     = 7'd64;
  localparam logic [SWEEP_BITS-1:0] SWEEPS_RESET   = 8'd10;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_SWEEPS = 2'd2;

  // accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

endpackage
`default_nettype wire

[rtl/jss_grid_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jss_grid_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jss_grid_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/jss_accum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jss_accum
// Shared neighbor accumulator: one adder sums four cells one at a time
// and yields the floor of the sum divided by four.
// ----------------------------------------------------------------------------
module jss_accum (
  input  wire logic                                  clk,
  input  wire jss_pkg::acc_op_t                      acc_op,
  input  wire logic signed [jss_pkg::CELL_BITS-1:0]  operand,
  output logic signed      [jss_pkg::CELL_BITS-1:0]  quarter
);

  logic signed [jss_pkg::ACC_BITS-1:0] acc_r;
  logic signed [jss_pkg::ACC_BITS-1:0] wide;
  logic signed [jss_pkg::ACC_BITS-1:0] sum;
  logic signed [jss_pkg::ACC_BITS-1:0] shifted;

  assign wide    = jss_pkg::ACC_BITS'(operand);
  assign sum     = acc_r + wide;
  // arithmetic shift gives the floor; the result always fits a cell
  assign shifted = sum >>> 2;
  assign quarter = shifted[jss_pkg::CELL_BITS-1:0];

  always_ff @(posedge clk) begin
    case (acc_op)
      jss_pkg::ACC_LOAD: acc_r <= wide;
      jss_pkg::ACC_ADD:  acc_r <= sum;
      default:           acc_r <= acc_r;
    endcase
  end

endmodule
`default_nettype wire

[rtl/jacobi_stencil_sweeps_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_stencil_sweeps_unit
// Jacobi five-point stencil engine over a double-buffered Q16.16 grid.
// ----------------------------------------------------------------------------
// A write word needs no read; a read word fetches its cell first. A run
// word sweeps the grid sweep_count times, each sweep a start step and
// then every cell of rows*cols in turn (interior cells take four neighbor
// reads, border cells are copied); with sweep_count zero it returns without
// sweeping. The single read port of the source buffer fetches the four
// neighbors one per cycle into a shared accumulator. One result word per
// input word; a finished result waits in an output register, and no new
// word is taken until it is accepted. The grid holds garbage until written.
module jacobi_stencil_sweeps_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [jss_pkg::CFG_BITS-1:0] cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // row_index[5:0], col_index[11:6], cell_in[43:12]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // cell_out[31:0], status[32]
);

  localparam int CB = jss_pkg::CELL_BITS;
  localparam int RB = jss_pkg::ROW_BITS;
  localparam int CLB = jss_pkg::COL_BITS;
  localparam int AB = jss_pkg::ADDR_BITS;
  localparam int DB = jss_pkg::DIM_BITS;
  localparam int SB = jss_pkg::SWEEP_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_CELL
  } state_t;

  state_t             state_r, state_nxt;
  logic [DB-1:0]      grid_rows_r, grid_rows_nxt;
  logic [DB-1:0]      grid_cols_r, grid_cols_nxt;
  logic [SB-1:0]      sweep_count_r, sweep_count_nxt;
  logic               cur_buf_r, cur_buf_nxt;
  logic [SB-1:0]      sweeps_left_r, sweeps_left_nxt;
  logic [RB-1:0]      row_r, row_nxt;
  logic [CLB-1:0]     col_r, col_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [CB-1:0]      cell_out_r, cell_out_nxt;
  logic               status_r, status_nxt;

  logic [1:0]         opcode;
  logic [RB-1:0]      row_index;
  logic [CLB-1:0]     col_index;
  logic [CB-1:0]      cell_in;
  logic               in_acc;
  logic [DB-1:0]      rows_used, cols_used;
  logic               addr_ok;
  logic               border, col_last, row_last;

  logic               even_we, odd_we;
  logic [AB-1:0]      wr_addr, rd_addr;
  logic [CB-1:0]      wr_data;
  logic [CB-1:0]      even_rd, odd_rd, src_rd;
  jss_pkg::acc_op_t   acc_op;
  logic signed [CB-1:0] quarter;

  assign opcode    = in_tuser;
  assign row_index = in_tdata[5:0];
  assign col_index = in_tdata[11:6];
  assign cell_in   = in_tdata[43:12];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, status_r, cell_out_r};

  // saturate oversized grid registers
  assign rows_used = (grid_rows_r > jss_pkg::MAX_ROWS) ? jss_pkg::MAX_ROWS : grid_rows_r;
  assign cols_used = (grid_cols_r > jss_pkg::MAX_COLS) ? jss_pkg::MAX_COLS : grid_cols_r;
  assign addr_ok   = ({1'b0, row_index} < rows_used) && ({1'b0, col_index} < cols_used);

  assign row_last = (({1'b0, row_r} + 7'd1) >= rows_used);
  assign col_last = (({1'b0, col_r} + 7'd1) >= cols_used);
  assign border   = (row_r == '0) || (col_r == '0) || row_last || col_last;

  assign src_rd = cur_buf_r ? odd_rd : even_rd;

  jss_grid_ram #(.ADDR_BITS(AB), .DATA_BITS(CB)) u_even (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (even_rd)
  );

  jss_grid_ram #(.ADDR_BITS(AB), .DATA_BITS(CB)) u_odd (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (odd_rd)
  );

  jss_accum u_accum (
    .clk     (clk),
    .acc_op  (acc_op),
    .operand (src_rd),
    .quarter (quarter)
  );

  // read address: the input cell, or in S_CELL the cell itself (border) or the phase's neighbor
  always_comb begin
    rd_addr = {row_index, col_index};
    if (state_r == S_CELL) begin
      if (border) begin
        rd_addr = {row_r, col_r};
      end else begin
        case (phase_r)
          3'd0:    rd_addr = {row_r - RB'(1), col_r};
          3'd1:    rd_addr = {row_r + RB'(1), col_r};
          3'd2:    rd_addr = {row_r, col_r - CLB'(1)};
          default: rd_addr = {row_r, col_r + CLB'(1)};
        endcase
      end
    end
  end

  always_comb begin
    acc_op = jss_pkg::ACC_HOLD;
    if (state_r == S_CELL && !border) begin
      case (phase_r)
        3'd1:       acc_op = jss_pkg::ACC_LOAD;
        3'd2, 3'd3: acc_op = jss_pkg::ACC_ADD;
        default:    acc_op = jss_pkg::ACC_HOLD;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    grid_rows_nxt   = grid_rows_r;
    grid_cols_nxt   = grid_cols_r;
    sweep_count_nxt = sweep_count_r;
    cur_buf_nxt     = cur_buf_r;
    sweeps_left_nxt = sweeps_left_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    phase_nxt       = phase_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    cell_out_nxt    = cell_out_r;
    status_nxt      = status_r;
    even_we         = 1'b0;
    odd_we          = 1'b0;
    wr_addr         = {row_index, col_index};
    wr_data         = cell_in;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jss_pkg::REG_ROWS:   grid_rows_nxt   = cfg_data[DB-1:0];
        jss_pkg::REG_COLS:   grid_cols_nxt   = cfg_data[DB-1:0];
        jss_pkg::REG_SWEEPS: sweep_count_nxt = cfg_data[SB-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (opcode)
            jss_pkg::OP_WRITE: begin
              even_we        = addr_ok;
              odd_we         = addr_ok;
              out_tvalid_nxt = 1'b1;
              cell_out_nxt   = '0;
              status_nxt     = !addr_ok;
            end
            jss_pkg::OP_READ: begin
              if (addr_ok) begin
                state_nxt = S_READ;
              end else begin
                out_tvalid_nxt = 1'b1;
                cell_out_nxt   = '0;
                status_nxt     = 1'b1;
              end
            end
            jss_pkg::OP_RUN: begin
              if (sweep_count_r == '0) begin
                out_tvalid_nxt = 1'b1;
                cell_out_nxt   = '0;
                status_nxt     = 1'b0;
              end else begin
                sweeps_left_nxt = sweep_count_r;
                state_nxt       = S_SWEEP;
              end
            end
            default: begin
              out_tvalid_nxt = 1'b1;
              cell_out_nxt   = '0;
              status_nxt     = 1'b0;
            end
          endcase
        end
      end

      S_READ: begin
        out_tvalid_nxt = 1'b1;
        cell_out_nxt   = src_rd;
        status_nxt     = 1'b0;
        state_nxt      = S_IDLE;
      end

      S_SWEEP: begin
        row_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = '0;
        if (rows_used == '0 || cols_used == '0) begin
          // empty grid: swap only
          cur_buf_nxt     = !cur_buf_r;
          sweeps_left_nxt = sweeps_left_r - SB'(1);
          if (sweeps_left_r == SB'(1)) begin
            out_tvalid_nxt = 1'b1;
            cell_out_nxt   = '0;
            status_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_CELL;
        end
      end

      S_CELL: begin
        wr_addr   = {row_r, col_r};
        wr_data   = border ? src_rd : quarter;
        phase_nxt = phase_r + 3'd1;
        if ((border && phase_r == 3'd1) || (!border && phase_r == 3'd4)) begin
          // write the destination buffer and advance to the next cell
          even_we   = cur_buf_r;
          odd_we    = !cur_buf_r;
          phase_nxt = '0;
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_r + RB'(1);
            if (row_last) begin
              cur_buf_nxt     = !cur_buf_r;
              sweeps_left_nxt = sweeps_left_r - SB'(1);
              if (sweeps_left_r == SB'(1)) begin
                out_tvalid_nxt = 1'b1;
                cell_out_nxt   = '0;
                status_nxt     = 1'b0;
                state_nxt      = S_IDLE;
              end else begin
                state_nxt = S_SWEEP;
              end
            end
          end else begin
            col_nxt = col_r + CLB'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      grid_rows_r   <= jss_pkg::ROWS_RESET;
      grid_cols_r   <= jss_pkg::COLS_RESET;
      sweep_count_r <= jss_pkg::SWEEPS_RESET;
      cur_buf_r     <= 1'b0;
      sweeps_left_r <= '0;
      row_r         <= '0;
      col_r         <= '0;
      phase_r       <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      grid_rows_r   <= grid_rows_nxt;
      grid_cols_r   <= grid_cols_nxt;
      sweep_count_r <= sweep_count_nxt;
      cur_buf_r     <= cur_buf_nxt;
      sweeps_left_r <= sweeps_left_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      phase_r       <= phase_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    cell_out_r <= cell_out_nxt;
    status_r   <= status_nxt;
  end

endmodule
`default_nettype wire
